### hw/rtl/scp_pkg.sv
// Shared constants and types for the strip chart column plotter.
package scp_pkg;

   // Chart geometry.
   localparam int CHART_WIDTH = 128;
   localparam int COL_W       = $clog2(CHART_WIDTH);
   localparam int OUT_COL_W   = 7;
   localparam int ROWS        = 64;

   // Input item codes.
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_ACCEL = 2'd1;
   localparam logic [1:0] KIND_JERK  = 2'd2;
   localparam logic [1:0] KIND_NONE  = 2'd3;

   // Last column before the chart starts to scroll.
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(CHART_WIDTH - 1);

   // Plotting mode and the previous sample, as seen by the mask logic.
   typedef struct packed {
      logic              delta_mode;
      logic signed [9:0] prev_sample;
   } mask_ctrl_type;

endpackage

### hw/rtl/scp_mask.sv
// Column mask generation for one sample in acceleration or jerk mode.
module scp_mask import scp_pkg::*; (
   input  logic signed [9:0]  sample,
   input  mask_ctrl_type      ctrl,
   output logic [ROWS-1:0]    pixels
);

   logic [9:0]  accel_off;
   logic [15:0] accel_prod;
   logic [5:0]  accel_q0;
   logic [10:0] accel_rem;
   logic [5:0]  accel_h;
   logic [5:0]  accel_top;

   logic signed [11:0] jerk_sum;
   logic [10:0] jerk_off;
   logic [15:0] jerk_prod;
   logic [5:0]  jerk_q0;
   logic [10:0] jerk_rem;
   logic [5:0]  jerk_q;
   logic [6:0]  jerk_edge;

   // Division by 1023 is done as a shift by 10 with one correction step:
   // the remainder after the shift is the low ten bits plus the quotient,
   // which stays below twice the divisor.
   always_comb begin
      accel_off  = 10'(12'(sample) + 12'sd512);
      accel_prod = 16'(accel_off) * 16'd63;
      accel_q0   = accel_prod[15:10];
      accel_rem  = 11'(accel_prod[9:0]) + 11'(accel_q0);
      accel_h    = (accel_rem >= 11'd1023) ? accel_q0 + 6'd1 : accel_q0;
      accel_top  = 6'd63 - accel_h;

      jerk_sum   = 12'(sample) - 12'(ctrl.prev_sample) + 12'sd1023;
      jerk_off   = jerk_sum[10:0];
      jerk_prod  = 16'(jerk_off) * 16'd31;
      jerk_q0    = jerk_prod[15:10];
      jerk_rem   = 11'(jerk_prod[9:0]) + 11'(jerk_q0);
      jerk_q     = (jerk_rem >= 11'd1023) ? jerk_q0 + 6'd1 : jerk_q0;
      // The bar ends at row 62 - q, above or below the centre row.
      jerk_edge  = 7'd62 - 7'(jerk_q);

      for (int y = 0; y < ROWS; y++) begin
         if (ctrl.delta_mode) begin
            pixels[y] = (y == 31) ||
                        ((y < 31) && (7'(y) >= jerk_edge)) ||
                        ((y > 31) && (7'(y) <= jerk_edge));
         end else begin
            pixels[y] = (6'(y) >= accel_top);
         end
      end
   end

endmodule

### hw/rtl/strip_chart_column_plotter.sv
// Top level of the strip chart column plotter: input register, state and result register.
// The mask logic sits between the input and result registers; the result register drives rsp_.
// Throughput: one item per cycle while no result waits on rsp_stall.
// Stalling: a full input register holds while a result waits, so req_stall follows rsp_stall.
// Reset clears the valid flags, the jerk mode, the previous sample and the write column.
// An item with the unused kind code is accepted and dropped without a result.
module strip_chart_column_plotter import scp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_kind,
   input  logic signed [9:0]     req_sample,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_clear_screen,
   output logic [OUT_COL_W-1:0]  rsp_column,
   output logic [ROWS-1:0]       rsp_column_pixels,
   output logic                  rsp_scroll_after
);

   // Input register. Items with the unused code never enter it.
   logic              in_valid_ff, in_valid_in;
   logic [1:0]        in_kind_ff, in_kind_in;
   logic signed [9:0] in_sample_ff, in_sample_in;

   // Block state.
   logic              delta_mode_ff, delta_mode_in;
   logic signed [9:0] prev_sample_ff, prev_sample_in;
   logic [COL_W-1:0]  write_column_ff, write_column_in;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_clear_ff, rsp_clear_in;
   logic [OUT_COL_W-1:0] rsp_column_ff, rsp_column_in;
   logic [ROWS-1:0]      rsp_pixels_ff, rsp_pixels_in;
   logic                 rsp_scroll_ff, rsp_scroll_in;

   logic            out_advance;
   logic            in_load;
   mask_ctrl_type   mask_ctrl;
   logic [ROWS-1:0] mask_pixels;
   logic [8:0]      col_wide;

   // The result register may take a new item when it is empty or being taken.
   assign out_advance = !rsp_valid_ff || !rsp_stall;
   // The input register holds only while its item cannot move on.
   assign req_stall   = in_valid_ff && !out_advance;
   assign in_load     = !req_stall;

   assign mask_ctrl.delta_mode  = delta_mode_ff;
   assign mask_ctrl.prev_sample = prev_sample_ff;

   scp_mask u_mask (
      .sample (in_sample_ff),
      .ctrl   (mask_ctrl),
      .pixels (mask_pixels)
   );

   // Only the low bits of the write column are reported on a wide chart.
   assign col_wide = 9'(write_column_ff);

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_kind_in   = in_kind_ff;
      in_sample_in = in_sample_ff;
      if (in_load) begin
         in_valid_in  = req_valid && (req_kind != KIND_NONE);
         in_kind_in   = req_kind;
         in_sample_in = req_sample;
      end
   end

   // State moves on as each item passes into the result register, so the
   // order of the updates follows the order of the items.
   always_comb begin
      delta_mode_in   = delta_mode_ff;
      prev_sample_in  = prev_sample_ff;
      write_column_in = write_column_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_clear_in    = rsp_clear_ff;
      rsp_column_in   = rsp_column_ff;
      rsp_pixels_in   = rsp_pixels_ff;
      rsp_scroll_in   = rsp_scroll_ff;
      if (out_advance) begin
         rsp_valid_in = in_valid_ff;
         if (in_valid_ff) begin
            prev_sample_in = in_sample_ff;
            unique case (in_kind_ff) inside
               KIND_ACCEL, KIND_JERK: begin
                  // A restart picks the mode and clears the chart.
                  delta_mode_in   = (in_kind_ff == KIND_JERK);
                  write_column_in = '0;
                  rsp_clear_in    = 1'b1;
                  rsp_column_in   = '0;
                  rsp_pixels_in   = '0;
                  rsp_scroll_in   = 1'b0;
               end
               default: begin
                  // A sample tick draws one column and moves on or scrolls.
                  rsp_clear_in  = 1'b0;
                  rsp_column_in = col_wide[OUT_COL_W-1:0];
                  rsp_pixels_in = mask_pixels;
                  if (write_column_ff >= COL_LAST) begin
                     rsp_scroll_in = 1'b1;
                  end else begin
                     rsp_scroll_in   = 1'b0;
                     write_column_in = write_column_ff + COL_W'(1);
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         delta_mode_ff   <= 1'b0;
         prev_sample_ff  <= '0;
         write_column_ff <= '0;
      end else begin
         in_valid_ff     <= in_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         delta_mode_ff   <= delta_mode_in;
         prev_sample_ff  <= prev_sample_in;
         write_column_ff <= write_column_in;
      end
   end

   always_ff @(posedge clock) begin
      in_kind_ff    <= in_kind_in;
      in_sample_ff  <= in_sample_in;
      rsp_clear_ff  <= rsp_clear_in;
      rsp_column_ff <= rsp_column_in;
      rsp_pixels_ff <= rsp_pixels_in;
      rsp_scroll_ff <= rsp_scroll_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_clear_screen  = rsp_clear_ff;
   assign rsp_column        = rsp_column_ff;
   assign rsp_column_pixels = rsp_pixels_ff;
   assign rsp_scroll_after  = rsp_scroll_ff;

   // The write column never passes the last column of the chart.
   assert property (@(posedge clock) disable iff (reset) write_column_ff <= COL_LAST)
      else $error("write column beyond chart");

   // A clear item carries an empty mask and no scroll.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_clear_ff |-> (rsp_pixels_ff == '0) && !rsp_scroll_ff)
      else $error("clear item with drawing content");

   // Every drawn column lights the bottom row or the centre row.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_clear_ff |-> rsp_pixels_ff[ROWS-1] || rsp_pixels_ff[31])
      else $error("drawn column has no anchor pixel");

   // The input side is held back only while a result is waiting.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("input stalled without a waiting result");

endmodule

### tb/strip_chart_column_plotter_tb.sv
// Self-checking testbench for the strip chart column plotter, with its own column predictor.
`timescale 1ns / 100ps

module strip_chart_column_plotter_tb;
   import scp_pkg::*;

   // The run is cut short here if the block stops answering. The slowest honest run is about
   // 1300 items, each with the longest sender gap and receiver stall, plus one long hold-off.
   localparam int CYCLE_LIMIT = 200000;

   // Length of the receiver hold-off in the back-pressure test, in cycles.
   localparam int HOLD_CYCLES = 60;

   // One column update as the chart driver would see it.
   typedef struct packed {
      logic                 clear_screen;
      logic [OUT_COL_W-1:0] column;
      logic [ROWS-1:0]      column_pixels;
      logic                 scroll_after;
   } column_plot_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [1:0]           req_kind;
   logic signed [9:0]    req_sample;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_clear_screen;
   logic [OUT_COL_W-1:0] rsp_column;
   logic [ROWS-1:0]      rsp_column_pixels;
   logic                 rsp_scroll_after;

   // The predictor's own copy of the plotting state.
   logic                 chart_delta_mode;
   logic signed [9:0]    chart_prev_sample;
   int                   chart_write_col;

   // Column updates that the block still owes us, oldest first.
   column_plot_type      pending_plots[$];

   // Idling controls: bursts of gaps from the sender, bursts of stalls from the receiver,
   // and a long hold-off that the receiver counts down in its own process.
   bit                   src_bursts;
   bit                   sink_bursts;
   int                   hold_left;
   int                   stall_left;

   int                   cycles;
   int                   items_sent;
   int                   plots_checked;
   int                   restarts_seen;
   int                   scrolls_seen;
   int                   jerk_plots;
   int                   mismatches;

   strip_chart_column_plotter dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_clear_screen  (rsp_clear_screen),
      .rsp_column        (rsp_column),
      .rsp_column_pixels (rsp_column_pixels),
      .rsp_scroll_after  (rsp_scroll_after)
   );

   // 10 ns clock, low for the first half period.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Rows lo to hi, both ends included, lit in a 64-row column.
   function automatic logic [ROWS-1:0] row_span(input int lo, input int hi);
      logic [ROWS-1:0] m;
      m = '0;
      for (int r = 0; r < ROWS; r++)
         if (r >= lo && r <= hi)
            m[r] = 1'b1;
      return m;
   endfunction

   // Works out the column update that one accepted item should cause, and moves the
   // predictor's state on. Returns 0 for the unused kind, which causes nothing at all.
   function automatic bit plot_column(input logic [1:0] kind, input logic signed [9:0] sample,
                                      output column_plot_type plot);
      int s;
      int h;
      int bar;
      plot = '0;
      s = sample;
      if (kind == KIND_NONE)
         return 1'b0;
      if (kind == KIND_ACCEL || kind == KIND_JERK) begin
         // A restart picks the mode, seeds the previous sample and clears the chart.
         chart_delta_mode  = (kind == KIND_JERK);
         chart_prev_sample = sample;
         chart_write_col   = 0;
         plot.clear_screen = 1'b1;
         return 1'b1;
      end
      plot.column = chart_write_col[OUT_COL_W-1:0];
      if (chart_delta_mode) begin
         // Signed bar about the middle row, drawn from the change since the last sample.
         bar = ((s - chart_prev_sample + 1023) * 62) / 2046 - 31;
         plot.column_pixels = row_span(31, 31);
         if (bar > 0)
            plot.column_pixels |= row_span(31 - bar, 30);
         else if (bar < 0)
            plot.column_pixels |= row_span(32, 31 - bar);
      end else begin
         // Bar rising from the bottom row; the bottom row is lit even at full negative scale.
         h = ((s + 512) * 63) / 1023;
         plot.column_pixels = row_span(63 - h, 63);
      end
      chart_prev_sample = sample;
      if (chart_write_col >= CHART_WIDTH - 1)
         plot.scroll_after = 1'b1;
      else
         chart_write_col++;
      return 1'b1;
   endfunction

   task automatic report_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   // Watches both channels at each rising edge. The input side is handled first, so an
   // expectation is always queued before the result it stands for could be compared.
   always @(posedge clock) begin : watch_channels
      column_plot_type expected;
      column_plot_type predicted;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            if (plot_column(req_kind, req_sample, predicted)) begin
               pending_plots.push_back(predicted);
               if (predicted.clear_screen)
                  restarts_seen++;
               if (predicted.scroll_after)
                  scrolls_seen++;
               if (!predicted.clear_screen && chart_delta_mode)
                  jerk_plots++;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_plots.size() == 0) begin
               $error("column update with none expected: column %0d, pixels %0h",
                      rsp_column, rsp_column_pixels);
               mismatches++;
            end else begin
               expected = pending_plots.pop_front();
               report_field("clear_screen", 64'(expected.clear_screen),
                            64'(rsp_clear_screen));
               report_field("column", 64'(expected.column), 64'(rsp_column));
               report_field("column_pixels", expected.column_pixels, rsp_column_pixels);
               report_field("scroll_after", 64'(expected.scroll_after),
                            64'(rsp_scroll_after));
               plots_checked++;
            end
         end
      end
   end

   // Receiver side. The long hold-off takes priority over the short random stall bursts,
   // and both are counted down here at the falling edge.
   initial begin
      rsp_stall  = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (sink_bursts && $urandom_range(0, 4) == 0) begin
            rsp_stall  <= 1'b1;
            stall_left = $urandom_range(1, 5) - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Cycle counter with a hard limit, in case a handshake never completes.
   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("strip_chart_column_plotter_tb: errors");
      $finish;
   end

   // Offers one item from a falling edge and waits until the block takes it. The task
   // returns at a falling edge with valid still high, so back-to-back items keep valid up.
   task automatic send_item(input logic [1:0] kind, input logic signed [9:0] sample);
      int gap;
      if (src_bursts && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_kind   <= kind;
      req_sample <= sample;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   // A sample that lands on the extremes and around zero more often than chance would.
   function automatic logic signed [9:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return -10'sd512;
         1:       return 10'sd511;
         2:       return 10'sd0;
         3:       return -10'sd1;
         default: return 10'($urandom);
      endcase
   endfunction

   // Bars in acceleration mode straight after reset: both ends of the scale and the
   // points where the bar height steps.
   task automatic test_accel_bars();
      send_item(KIND_TICK, -10'sd512);
      send_item(KIND_TICK, 10'sd511);
      send_item(KIND_TICK, 10'sd0);
      send_item(KIND_TICK, -10'sd1);
      send_item(KIND_TICK, -10'sd496);
      send_item(KIND_TICK, 10'sd495);
      send_item(KIND_TICK, 10'sd1);
   endtask

   // Jerk bars at full positive and negative swing, at no change and at small steps.
   task automatic test_jerk_bars();
      send_item(KIND_JERK, -10'sd512);
      send_item(KIND_TICK, 10'sd511);
      send_item(KIND_JERK, 10'sd511);
      send_item(KIND_TICK, -10'sd512);
      send_item(KIND_TICK, -10'sd512);
      send_item(KIND_TICK, -10'sd511);
      send_item(KIND_TICK, -10'sd478);
      send_item(KIND_TICK, -10'sd512);
   endtask

   // The unused kind must leave the column and the previous sample untouched, and the
   // restart in acceleration mode must clear the chart and begin again at the first column.
   task automatic test_unused_kind_and_restart();
      send_item(KIND_NONE, 10'sd511);
      send_item(KIND_TICK, -10'sd300);
      send_item(KIND_NONE, -10'sd512);
      send_item(KIND_TICK, 10'sd200);
      send_item(KIND_ACCEL, 10'sd511);
      send_item(KIND_TICK, 10'sd511);
      send_item(KIND_ACCEL, -10'sd512);
      send_item(KIND_TICK, -10'sd512);
   endtask

   // Runs the chart past its right edge in both modes, so the column sticks at the last
   // one and the scroll flag is raised for every further sample.
   task automatic test_scroll_edge();
      send_item(KIND_ACCEL, pick_sample());
      repeat (CHART_WIDTH + 12) send_item(KIND_TICK, pick_sample());
      send_item(KIND_JERK, pick_sample());
      repeat (CHART_WIDTH + 12) send_item(KIND_TICK, pick_sample());
   endtask

   // The receiver holds off for a long stretch while items keep coming, so the block
   // fills up and must stall its input until the receiver lets go.
   task automatic test_back_pressure();
      hold_left = HOLD_CYCLES;
      repeat (40) send_item(KIND_TICK, pick_sample());
   endtask

   // Mostly long runs of samples with random content, so the chart scrolls in both modes,
   // broken now and then by a restart or by an item of the unused kind.
   task automatic test_random_traffic(input int count);
      int roll;
      repeat (count) begin
         roll = $urandom_range(0, 199);
         if (roll == 0)
            send_item(KIND_ACCEL, pick_sample());
         else if (roll == 1)
            send_item(KIND_JERK, pick_sample());
         else if (roll < 8)
            send_item(KIND_NONE, pick_sample());
         else
            send_item(KIND_TICK, pick_sample());
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_kind    = KIND_TICK;
      req_sample  = '0;
      src_bursts  = 1'b0;
      sink_bursts = 1'b0;
      hold_left   = 0;
      items_sent    = 0;
      plots_checked = 0;
      restarts_seen = 0;
      scrolls_seen  = 0;
      jerk_plots    = 0;
      mismatches    = 0;

      // The predictor starts from the reset state of the block.
      chart_delta_mode  = 1'b0;
      chart_prev_sample = '0;
      chart_write_col   = 0;

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed tests, then random traffic, with both sides idling at random.
      src_bursts  = 1'b1;
      sink_bursts = 1'b1;
      test_accel_bars();
      test_jerk_bars();
      test_unused_kind_and_restart();
      test_scroll_edge();
      test_back_pressure();
      test_random_traffic(750);

      // Last stretch at full rate on both sides.
      src_bursts  = 1'b0;
      sink_bursts = 1'b0;
      test_random_traffic(150);
      req_valid <= 1'b0;

      while (pending_plots.size() != 0)
         @(posedge clock);
      repeat (5) @(posedge clock);

      $display("Sent %0d items and checked %0d column updates (%0d in jerk mode).",
               items_sent, plots_checked, jerk_plots);
      $display("Saw %0d restarts and %0d columns drawn with the chart scrolling.",
               restarts_seen, scrolls_seen);
      if (mismatches == 0 && pending_plots.size() == 0)
         $display("strip_chart_column_plotter_tb: clean");
      else
         $display("strip_chart_column_plotter_tb: errors");
      $finish;
   end

endmodule
